FILE: rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared constants, request/response payload types and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

	localparam int MaxKnots = 256;
	localparam int IdxW     = $clog2(MaxKnots);
	localparam int CountW   = 9;
	localparam int DataW    = 32;
	localparam int FracW    = 16;

	localparam logic CmdWrite = 1'b0;
	localparam logic CmdQuery = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic [7:0]              knot_index;
		logic signed [DataW-1:0] coord;
		logic signed [DataW-1:0] knot_value;
		logic                    restart;
	} req_t;

	typedef struct packed {
		logic signed [DataW-1:0] value_out;
		logic                    out_of_range;
	} rsp_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_READ  = 7'b0000010,
		ST_CHECK = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_SUM   = 7'b0100000,
		ST_RSP   = 7'b1000000
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/pli_ram.sv
// ----------------------------------------------------------------------------
// Knot table RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr_a,
	input  wire logic [$clog2(Depth)-1:0] raddr_b,
	output logic      [Width-1:0]         rdata_a,
	output logic      [Width-1:0]         rdata_b
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

FILE: rtl/core/pli_div.sv
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider, one quotient bit per cycle: quo = floor(num * 2^16 / den)
// for num < den.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pli_pkg::DataW-1:0]   num,
	input  wire logic [pli_pkg::DataW-1:0]   den,
	output logic                             busy,
	output logic      [pli_pkg::FracW-1:0]   quo
);

	localparam int CntW = $clog2(pli_pkg::FracW + 1);

	logic [pli_pkg::DataW-1:0] rem_q;
	logic [pli_pkg::DataW-1:0] den_q;
	logic [pli_pkg::FracW-1:0] quo_q;
	logic [CntW-1:0]           cnt_q;
	logic                      busy_q;
	logic [pli_pkg::DataW:0]   rem_sh;
	logic [pli_pkg::DataW:0]   rem_sub;
	logic                      fits;

	always_comb begin
		rem_sh  = {rem_q, 1'b0};
		rem_sub = rem_sh - {1'b0, den_q};
		fits    = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(pli_pkg::FracW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[pli_pkg::DataW-1:0] : rem_sh[pli_pkg::DataW-1:0];
			quo_q <= {quo_q[pli_pkg::FracW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Knot write: no response; the request port stays ready, as the sequencer stays idle.
// Query: ST_READ/ST_CHECK walk the segment pointer; an exact knot match or out
// of range goes to ST_RSP, else ST_DIV (16 divider steps), ST_MUL, ST_SUM, ST_RSP;
// one request in flight, new requests stall until the response is taken.
// Reset: segment pointer 0, knot_count 2; knot table contents undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire pli_pkg::req_t                  req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output pli_pkg::rsp_t                       rsp,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [pli_pkg::CountW-1:0]     cfg_data
);

	localparam int IdxW  = pli_pkg::IdxW;
	localparam int DataW = pli_pkg::DataW;
	localparam int FracW = pli_pkg::FracW;
	localparam int DiffW = DataW + 1;
	localparam int ProdW = DiffW + FracW + 1;
	localparam int SumW  = ProdW + 1;
	localparam int QW    = SumW - FracW;

	pli_pkg::state_t state_q;

	logic [pli_pkg::CountW-1:0] knot_count_q;
	logic [IdxW-1:0]            ptr_q;
	logic [IdxW-1:0]            seg_q;
	logic [IdxW-1:0]            last_q;
	logic signed [DataW-1:0]    x_q;
	logic signed [DataW-1:0]    fl_q;
	logic signed [DiffW-1:0]    d_q;
	logic signed [ProdW-1:0]    prod_q;
	pli_pkg::rsp_t              rsp_q;

	logic                       accept;
	logic                       ram_we;
	logic [IdxW-1:0]            seg_next;
	logic signed [DataW-1:0]    pos_a;
	logic signed [DataW-1:0]    pos_b;
	logic signed [DataW-1:0]    val_a;
	logic signed [DataW-1:0]    val_b;
	logic [pli_pkg::CountW-1:0] n_use;
	logic [IdxW-1:0]            last_seg;
	logic [IdxW-1:0]            seg_init;
	logic                       advance;
	logic                       hit_r;
	logic                       outside;
	logic                       div_start;
	logic                       div_busy;
	logic [FracW-1:0]           frac;
	logic [DataW-1:0]           div_num;
	logic [DataW-1:0]           div_den;
	logic signed [SumW-1:0]     sum;
	logic signed [QW-1:0]       q;
	logic signed [DataW-1:0]    q_sat;

	assign cfg_ready = 1'b1;
	assign req_stall = state_q != pli_pkg::ST_IDLE;
	assign accept    = req_valid && !req_stall;
	assign ram_we    = accept && req.cmd == pli_pkg::CmdWrite;
	assign rsp_valid = state_q == pli_pkg::ST_RSP;
	assign rsp       = rsp_q;
	assign seg_next  = seg_q + 1'b1;

	always_comb begin
		if (knot_count_q < pli_pkg::CountW'(2)) begin
			n_use = pli_pkg::CountW'(2);
		end else if (knot_count_q > pli_pkg::CountW'(pli_pkg::MaxKnots)) begin
			n_use = pli_pkg::CountW'(pli_pkg::MaxKnots);
		end else begin
			n_use = knot_count_q;
		end
		last_seg = IdxW'(n_use - pli_pkg::CountW'(2));
		seg_init = req.restart ? '0 : ptr_q;
		if (seg_init > last_seg) begin
			seg_init = last_seg;
		end
	end

	always_comb begin
		advance   = seg_q < last_q && x_q > pos_b;
		hit_r     = x_q == pos_b;
		outside   = x_q > pos_b || x_q < pos_a;
		div_start = state_q == pli_pkg::ST_CHECK && !advance && !hit_r && !outside;
		div_num   = DataW'(x_q - pos_a);
		div_den   = DataW'(pos_b - pos_a);
	end

	always_comb begin
		sum = (SumW'(fl_q) <<< FracW) + SumW'(prod_q);
		q   = sum[SumW-1:FracW];
		if (q > QW'(signed'({1'b0, {(DataW-1){1'b1}}}))) begin
			q_sat = {1'b0, {(DataW-1){1'b1}}};
		end else if (q < QW'(signed'({1'b1, {(DataW-1){1'b0}}}))) begin
			q_sat = {1'b1, {(DataW-1){1'b0}}};
		end else begin
			q_sat = q[DataW-1:0];
		end
	end

	pli_ram #(
		.Width(DataW),
		.Depth(pli_pkg::MaxKnots)
	) u_pos_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (req.knot_index[IdxW-1:0]),
		.wdata   (req.coord),
		.raddr_a (seg_q),
		.raddr_b (seg_next),
		.rdata_a (pos_a),
		.rdata_b (pos_b)
	);

	pli_ram #(
		.Width(DataW),
		.Depth(pli_pkg::MaxKnots)
	) u_val_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (req.knot_index[IdxW-1:0]),
		.wdata   (req.knot_value),
		.raddr_a (seg_q),
		.raddr_b (seg_next),
		.rdata_a (val_a),
		.rdata_b (val_b)
	);

	pli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (frac)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pli_pkg::ST_IDLE;
			knot_count_q <= pli_pkg::CountW'(2);
			ptr_q        <= '0;
			seg_q        <= '0;
			last_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				knot_count_q <= cfg_data;
			end
			case (state_q)
				pli_pkg::ST_IDLE: begin
					if (accept && req.cmd == pli_pkg::CmdQuery) begin
						seg_q   <= seg_init;
						last_q  <= last_seg;
						state_q <= pli_pkg::ST_READ;
					end
				end
				pli_pkg::ST_READ: begin
					state_q <= pli_pkg::ST_CHECK;
				end
				pli_pkg::ST_CHECK: begin
					if (advance) begin
						seg_q   <= seg_next;
						state_q <= pli_pkg::ST_READ;
					end else if (hit_r) begin
						ptr_q   <= (seg_q < last_q) ? seg_next : seg_q;
						state_q <= pli_pkg::ST_RSP;
					end else if (outside) begin
						ptr_q   <= seg_q;
						state_q <= pli_pkg::ST_RSP;
					end else begin
						ptr_q   <= seg_q;
						state_q <= pli_pkg::ST_DIV;
					end
				end
				pli_pkg::ST_DIV: begin
					if (!div_busy) begin
						state_q <= pli_pkg::ST_MUL;
					end
				end
				pli_pkg::ST_MUL: begin
					state_q <= pli_pkg::ST_SUM;
				end
				pli_pkg::ST_SUM: begin
					state_q <= pli_pkg::ST_RSP;
				end
				pli_pkg::ST_RSP: begin
					if (!rsp_stall) begin
						state_q <= pli_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pli_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= req.coord;
		end
		if (state_q == pli_pkg::ST_CHECK) begin
			fl_q <= val_a;
			d_q  <= DiffW'(val_b) - DiffW'(val_a);
			if (hit_r) begin
				rsp_q.value_out    <= val_b;
				rsp_q.out_of_range <= 1'b0;
			end else begin
				rsp_q.value_out    <= '0;
				rsp_q.out_of_range <= 1'b1;
			end
		end
		if (state_q == pli_pkg::ST_MUL) begin
			prod_q <= signed'({1'b0, frac}) * d_q;
		end
		if (state_q == pli_pkg::ST_SUM) begin
			rsp_q.value_out    <= q_sat;
			rsp_q.out_of_range <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/piecewise_linear_interpolator_tb.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator testbench
// Loads knot tables of several sizes, streams sorted and disordered queries
// with random gaps and response stalls, and checks every response against a
// cycle-free model of the segment walk and the Q16.16 interpolation.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pli_pkg::*;

	localparam int     RequestBudget = 1850;
	localparam int     CycleLimit    = 5_000_000;
	localparam int     LongHold      = 400;
	localparam longint CoordMin      = -64'sd2147483648;
	localparam longint CoordMax      = 64'sd2147483647;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req       = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CountW-1:0] cfg_data  = '0;

	logic signed [DataW-1:0] knot_pos [MaxKnots];
	logic signed [DataW-1:0] knot_val [MaxKnots];
	int unsigned             seg_ptr    = 0;
	logic [CountW-1:0]       count_reg  = CountW'(2);
	int                      live_knots = 2;
	rsp_t                    awaited_answers [$];

	int errors        = 0;
	int requests_sent = 0;
	int cycles        = 0;
	bit gap_enable    = 1'b1;
	bit stall_enable  = 1'b1;
	bit hold_request  = 1'b0;
	int hold_left     = 0;
	int stall_run     = 0;

	always #5 clk = ~clk;

	piecewise_linear_interpolator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	function automatic int effective_knots(input logic [CountW-1:0] v);
		if (v < 2)
			return 2;
		if (v > MaxKnots)
			return MaxKnots;
		return int'(v);
	endfunction

	function automatic longint rand_between(input longint lo, input longint hi);
		return lo + longint'($urandom_range(0, 32'(hi - lo)));
	endfunction

	function automatic longint rand_coord();
		return longint'(int'($urandom));
	endfunction

	function automatic req_t knot_req(input int idx, input longint pos, input longint val);
		req_t r;
		r.cmd        = CmdWrite;
		r.knot_index = idx[7:0];
		r.coord      = pos[DataW-1:0];
		r.knot_value = val[DataW-1:0];
		r.restart    = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic req_t query_req(input longint x, input bit rs);
		req_t r;
		r.cmd        = CmdQuery;
		r.knot_index = 8'($urandom_range(0, 255));
		r.coord      = x[DataW-1:0];
		r.knot_value = DataW'($urandom);
		r.restart    = rs;
		return r;
	endfunction

	task automatic predict_answer(input req_t r);
		int unsigned last_seg, seg;
		longint      x, xl, xr, fl, fr, c, s, q;
		rsp_t        a;
		if (r.cmd == CmdWrite) begin
			knot_pos[r.knot_index] = r.coord;
			knot_val[r.knot_index] = r.knot_value;
			return;
		end
		last_seg = effective_knots(count_reg) - 2;
		if (r.restart)
			seg_ptr = 0;
		if (seg_ptr > last_seg)
			seg_ptr = last_seg;
		x   = $signed(r.coord);
		seg = seg_ptr;
		while (seg < last_seg && x > longint'(knot_pos[seg + 1]))
			seg++;
		seg_ptr = seg;
		xl = knot_pos[seg];
		xr = knot_pos[seg + 1];
		fl = knot_val[seg];
		fr = knot_val[seg + 1];
		a.out_of_range = 1'b0;
		if (x == xr) begin
			q = fr;
			if (seg_ptr < last_seg)
				seg_ptr++;
		end else if (x > xr || x < xl) begin
			q = 0;
			a.out_of_range = 1'b1;
		end else begin
			c = ((x - xl) <<< FracW) / (xr - xl);
			s = ((longint'(1) <<< FracW) - c) * fl + c * fr;
			q = s >>> FracW;
			if (q > CoordMax)
				q = CoordMax;
			else if (q < CoordMin)
				q = CoordMin;
		end
		a.value_out = q[DataW-1:0];
		awaited_answers.insert(awaited_answers.size(), a);
	endtask

	task automatic send_request(input req_t r);
		int gap;
		gap = 0;
		if (gap_enable && $urandom_range(0, 99) < 30)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_answer(r);
		requests_sent++;
	endtask

	task automatic release_request();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic write_knot_count(input logic [CountW-1:0] v);
		release_request();
		while (awaited_answers.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		count_reg  = v;
		live_knots = effective_knots(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_table(input int n, input bit wide);
		longint ps [$];
		longint p, v;
		int     k;
		if (wide) begin
			repeat (n) begin
				p = rand_coord();
				k = ps.size();
				while (k > 0 && ps[k-1] > p)
					k--;
				ps.insert(k, p);
			end
		end else begin
			p = rand_between(-64'sd1048576, 64'sd1048576);
			repeat (n) begin
				ps.insert(ps.size(), p);
				if ($urandom_range(0, 1) != 0)
					p += $urandom_range(1, 4);
				else
					p += $urandom_range(1, 196608);
			end
		end
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 1) != 0)
				v = rand_coord();
			else
				v = rand_between(-64'sd1048576, 64'sd1048576);
			send_request(knot_req(k, ps[k], v));
		end
	endtask

	task automatic run_query_pass(input int n, input int count);
		longint xs [$];
		longint lo, hi, x, a, b;
		int     j, k;
		lo = knot_pos[0];
		hi = knot_pos[n-1];
		repeat (count) begin
			j = $urandom_range(0, n - 2);
			a = knot_pos[j];
			b = knot_pos[j + 1];
			case ($urandom_range(0, 19))
				0: x = (lo > CoordMin) ? rand_between(CoordMin, lo - 1) : lo;
				1: x = (hi < CoordMax) ? rand_between(hi + 1, CoordMax) : hi;
				2, 3, 4, 5: x = knot_pos[$urandom_range(0, n - 1)];
				default: x = (a < b) ? rand_between(a, b) : a;
			endcase
			k = xs.size();
			while (k > 0 && xs[k-1] > x)
				k--;
			xs.insert(k, x);
		end
		// occasionally swap two queries so the stream runs backwards
		if ($urandom_range(0, 9) == 0) begin
			j = $urandom_range(0, count - 1);
			k = $urandom_range(0, count - 1);
			x = xs[j];
			xs[j] = xs[k];
			xs[k] = x;
		end
		foreach (xs[i]) begin
			if ($urandom_range(0, 29) == 0)
				send_request(knot_req($urandom_range(0, MaxKnots - 1), rand_coord(), rand_coord()));
			send_request(query_req(xs[i], i == 0 || $urandom_range(0, 49) == 0));
		end
	endtask

	task automatic test_directed();
		write_knot_count(CountW'(4));
		send_request(knot_req(0, CoordMin, CoordMax));
		send_request(knot_req(1, 0, CoordMin));
		send_request(knot_req(2, 64'sh10000, 64'sh12345));
		send_request(knot_req(3, CoordMax, -1));
		send_request(knot_req(255, 64'sh5A5A5A5A, -64'sh5A5A5A5B));
		send_request(query_req(CoordMin, 1'b1));
		send_request(query_req(-1, 1'b0));
		send_request(query_req(0, 1'b0));
		send_request(query_req(64'sh8000, 1'b0));
		send_request(query_req(64'sh10000, 1'b0));
		send_request(query_req(CoordMax, 1'b0));
		send_request(query_req(64'sh4000, 1'b0));
		send_request(knot_req(3, 64'sh20000, 64'sh30000));
		send_request(query_req(CoordMax, 1'b1));
		send_request(knot_req(0, -64'sh10000, 5));
		send_request(query_req(CoordMin, 1'b1));
		send_request(knot_req(1, -64'sh10000, 7));
		send_request(query_req(-64'sh10000, 1'b1));
		send_request(query_req(-64'sh8000, 1'b0));
	endtask

	task automatic test_full_table();
		write_knot_count(CountW'(MaxKnots));
		load_table(MaxKnots, 1'b1);
		run_query_pass(MaxKnots, 60);
		run_query_pass(MaxKnots, 60);
	endtask

	task automatic test_backpressure();
		stall_enable = 1'b0;
		gap_enable   = 1'b0;
		hold_request = 1'b1;
		run_query_pass(live_knots, 30);
		gap_enable   = 1'b1;
		stall_enable = 1'b1;
	endtask

	task automatic test_count_clamping();
		logic [CountW-1:0] counts [4] = '{CountW'(511), CountW'(257), CountW'(0), CountW'(1)};
		foreach (counts[i]) begin
			write_knot_count(counts[i]);
			run_query_pass(live_knots, 15);
		end
	endtask

	task automatic test_random_phases();
		int n, sel;
		while (requests_sent < RequestBudget) begin
			sel = $urandom_range(0, 19);
			if (sel < 14)
				n = $urandom_range(2, 8);
			else if (sel < 19)
				n = $urandom_range(9, 40);
			else
				n = $urandom_range(41, MaxKnots);
			if (n == 2 && $urandom_range(0, 1) != 0)
				write_knot_count(CountW'($urandom_range(0, 1)));
			else
				write_knot_count(CountW'(n));
			gap_enable   = $urandom_range(0, 3) != 0;
			stall_enable = $urandom_range(0, 3) != 0;
			load_table(n, 1'($urandom_range(0, 1)));
			repeat ($urandom_range(1, 3))
				run_query_pass(n, $urandom_range(8, 40));
			if ($urandom_range(0, 4) == 0) begin
				repeat (10)
					send_request(query_req(rand_coord(), $urandom_range(0, 3) == 0));
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = LongHold;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
			rsp_stall <= 1'b1;
		end else if (stall_enable && $urandom_range(0, 99) < 20) begin
			stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_answers
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_answers.size() == 0) begin
				$error("unexpected response value_out=%0d out_of_range=%0b",
					rsp.value_out, rsp.out_of_range);
				errors++;
			end else begin
				want = awaited_answers.pop_front();
				if (rsp.value_out !== want.value_out) begin
					$error("value_out expected %0d actual %0d", want.value_out, rsp.value_out);
					errors++;
				end
				if (rsp.out_of_range !== want.out_of_range) begin
					$error("out_of_range expected %0b actual %0b",
						want.out_of_range, rsp.out_of_range);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("piecewise_linear_interpolator verification failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_table();
		test_backpressure();
		test_count_clamping();
		test_random_phases();
		release_request();
		while (awaited_answers.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && awaited_answers.size() == 0)
			$display("piecewise_linear_interpolator verification clean");
		else
			$display("piecewise_linear_interpolator verification failed");
		$finish;
	end

endmodule
